// ===== design/lorawan_payload_cipher_unit_macros.svh =====
// Assertion macros for the payload cipher unit.
`ifndef LORAWAN_PAYLOAD_CIPHER_UNIT_MACROS_SVH
`define LORAWAN_PAYLOAD_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define LPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/lpc_pkg.sv =====
// Shared types, constants and AES helper functions for the payload cipher.
package lpc_pkg;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // register indexes on the configuration port
   localparam logic [1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [1:0] REG_KEY_HIGH = 2'd1;
   localparam logic [1:0] REG_DEV_ADDR = 2'd2;

   localparam logic [7:0] BLOCK_TAG  = 8'h01;
   localparam logic [3:0] LAST_ROUND = 4'd10;
   localparam logic [3:0] LAST_BYTE  = 4'd15;

   // one classified payload byte, front to back
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [3:0]  idx;
      logic        start;
      logic [15:0] ctr;
      logic        dir;
      logic [7:0]  blk;
   } lpc_item_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // multiply by x in GF(2^8)
   function automatic logic [7:0] gf_dbl(input logic [7:0] x);
      gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // next round key; byte i of the key sits in bits 8i+7:8i
   function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
      logic [7:0] t [4];
      logic [127:0] nk;
      t[0] = SBOX[rk[111:104]] ^ rc;
      t[1] = SBOX[rk[119:112]];
      t[2] = SBOX[rk[127:120]];
      t[3] = SBOX[rk[103:96]];
      nk = '0;
      for (int c = 0; c < 4; c++) begin
         nk[8*c +: 8] = rk[8*c +: 8] ^ t[c];
      end
      for (int b = 4; b < 16; b++) begin
         nk[8*b +: 8] = rk[8*b +: 8] ^ nk[8*(b-4) +: 8];
      end
      key_next = nk;
   endfunction

   // SubBytes, ShiftRows and (unless final) MixColumns
   function automatic logic [127:0] aes_round(input logic [127:0] st, input logic fin);
      logic [7:0] tmp [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         tmp[i] = SBOX[st[8*((((i >> 2) + (i & 3)) & 3) * 4 + (i & 3)) +: 8]];
      end
      res = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = tmp[4*c];
         a1 = tmp[4*c+1];
         a2 = tmp[4*c+2];
         a3 = tmp[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (fin) begin
            res[32*c +: 32] = {a3, a2, a1, a0};
         end else begin
            res[32*c +: 32] = {a3 ^ all ^ gf_dbl(a3 ^ a0), a2 ^ all ^ gf_dbl(a2 ^ a3),
                               a1 ^ all ^ gf_dbl(a1 ^ a2), a0 ^ all ^ gf_dbl(a0 ^ a1)};
         end
      end
      aes_round = res;
   endfunction

endpackage

// ===== design/lpc_front.sv =====
// Front end: accepts payload bytes and tags them with frame and block position.
module lpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           req_in_byte,
   input  logic [15:0]          req_frame_counter,
   input  logic                 req_link_direction,
   input  logic                 req_frame_end,
   output lpc_pkg::lpc_item_type item
);
   import lpc_pkg::*;

   logic [3:0]  bib_ff, bib_in;
   logic [7:0]  bn_ff, bn_in;
   logic        inside_ff, inside_in;
   logic [15:0] ctr_ff, ctr_in;
   logic        dir_ff, dir_in;
   logic [3:0]  idx;
   logic [7:0]  bn;

   // frame start restarts position and latches counter and direction
   always_comb begin
      idx    = inside_ff ? bib_ff : 4'd0;
      bn     = inside_ff ? bn_ff : 8'd0;
      ctr_in = inside_ff ? ctr_ff : req_frame_counter;
      dir_in = inside_ff ? dir_ff : req_link_direction;
      bib_in = idx + 4'd1;
      bn_in  = (idx == LAST_BYTE) ? bn + 8'd1 : bn;
      inside_in = !req_frame_end;
      item.data  = req_in_byte;
      item.last  = req_frame_end;
      item.idx   = idx;
      item.start = (idx == 4'd0);
      item.ctr   = ctr_in;
      item.dir   = dir_in;
      item.blk   = bn + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bib_ff    <= '0;
         bn_ff     <= '0;
         inside_ff <= 1'b0;
         ctr_ff    <= '0;
         dir_ff    <= 1'b0;
      end else if (accept) begin
         bib_ff    <= bib_in;
         bn_ff     <= bn_in;
         inside_ff <= inside_in;
         ctr_ff    <= ctr_in;
         dir_ff    <= dir_in;
      end
   end
endmodule

// ===== design/lpc_fifo.sv =====
// Short queue of classified bytes between front and back.
module lpc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr,
   input  lpc_pkg::lpc_item_type wr_item,
   output logic                  full,
   input  logic                  rd,
   output logic                  head_valid,
   output lpc_pkg::lpc_item_type head
);
   import lpc_pkg::*;

   lpc_item_type   mem_ff [QDEPTH];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0]   cnt_ff;

   assign full       = (cnt_ff == QAW'(0) + (QAW+1)'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + QAW'(1);
         if (rd) rp_ff <= rp_ff + QAW'(1);
         cnt_ff <= cnt_ff + (QAW+1)'(wr) - (QAW+1)'(rd);
      end
   end
endmodule

// ===== design/lpc_back.sv =====
// Back end: round-iterative AES keystream engine and output register.
module lpc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  lpc_pkg::lpc_item_type head,
   output logic                  head_pop,
   input  logic [127:0]          key,
   input  logic [31:0]           dev_addr,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_last
);
   import lpc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] rk_ff, rk_in;
   logic [7:0]   rc_ff, rc_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [127:0] ks_ff;
   logic         ks_ok_ff, ks_ok_in;
   logic         ov_ff, ov_in;
   logic [7:0]   ob_ff;
   logic         ol_ff;
   logic [127:0] blk_a, nk, nst;
   logic         slot_free, start_calc, done;

   // counter block A_i
   always_comb begin
      blk_a = '0;
      blk_a[7:0]     = BLOCK_TAG;
      blk_a[47:40]   = {7'd0, head.dir};
      blk_a[55:48]   = dev_addr[31:24];
      blk_a[63:56]   = dev_addr[23:16];
      blk_a[71:64]   = dev_addr[15:8];
      blk_a[79:72]   = dev_addr[7:0];
      blk_a[87:80]   = head.ctr[7:0];
      blk_a[95:88]   = head.ctr[15:8];
      blk_a[127:120] = head.blk;
   end

   assign nk  = key_next(rk_ff, rc_ff);
   assign nst = aes_round(st_ff, rnd_ff == LAST_ROUND) ^ nk;
   assign done = (state_ff == ST_CALC) && (rnd_ff == LAST_ROUND);

   assign slot_free  = !ov_ff || rsp_pop;
   assign start_calc = (state_ff == ST_IDLE) && head_valid && head.start && !ks_ok_ff;
   assign head_pop   = (state_ff == ST_IDLE) && head_valid && slot_free &&
                       (!head.start || ks_ok_ff);

   // engine control
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      rk_in    = rk_ff;
      rc_in    = rc_ff;
      rnd_in   = rnd_ff;
      ks_ok_in = ks_ok_ff;
      if (head_pop && head.start) ks_ok_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start_calc) begin
               st_in    = blk_a ^ key;
               rk_in    = key;
               rc_in    = 8'h01;
               rnd_in   = 4'd1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            st_in  = nst;
            rk_in  = nk;
            rc_in  = gf_dbl(rc_ff);
            rnd_in = rnd_ff + 4'd1;
            if (done) begin
               ks_ok_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ks_ok_ff <= 1'b0;
         rnd_ff   <= '0;
         rc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ks_ok_ff <= ks_ok_in;
         rnd_ff   <= rnd_in;
         rc_ff    <= rc_in;
      end
   end

   // datapath and keystream, no reset needed
   always_ff @(posedge clock) begin
      st_ff <= st_in;
      rk_ff <= rk_in;
      if (done) ks_ff <= nst;
   end

   // output register
   always_comb begin
      ov_in = ov_ff;
      if (rsp_pop) ov_in = 1'b0;
      if (head_pop) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         ob_ff <= head.data ^ ks_ff[{head.idx, 3'b000} +: 8];
         ol_ff <= head.last;
      end
   end

   assign rsp_empty    = !ov_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_out_last = ol_ff;
endmodule

// ===== design/lorawan_payload_cipher_unit.sv =====
// Top level: LoRaWAN payload cipher with APB-style register port.
// A byte inside a block passes the queue and then the output register; the first byte of
// each 16-byte block also waits while the round-iterative AES core runs.
// Throughput: one byte per cycle inside a block while results are popped, with a stall at
// each block start set by the one-round-per-cycle AES core.
// Reset (synchronous, active high) clears registers, frame state, queue and output.
module lorawan_payload_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_in_byte,
   input  logic [15:0] req_frame_counter,
   input  logic        req_link_direction,
   input  logic        req_frame_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import lpc_pkg::*;
`include "lorawan_payload_cipher_unit_macros.svh"

   logic [63:0]  key_low_ff, key_high_ff;
   logic [31:0]  addr_ff;
   logic         wr_en, accept, head_valid, head_pop;
   lpc_item_type item, head;

   // register port
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         addr_ff     <= '0;
      end else if (wr_en) begin
         case (csr_paddr[4:3])
            REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_DEV_ADDR: addr_ff     <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_DEV_ADDR: csr_prdata = {32'd0, addr_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign accept = req_push && !req_full;

   lpc_front u_front (
      .clock, .reset, .accept,
      .req_in_byte, .req_frame_counter, .req_link_direction, .req_frame_end,
      .item
   );

   lpc_fifo u_fifo (
      .clock, .reset,
      .wr(accept), .wr_item(item), .full(req_full),
      .rd(head_pop), .head_valid, .head
   );

   lpc_back u_back (
      .clock, .reset,
      .head_valid, .head, .head_pop,
      .key({key_high_ff, key_low_ff}), .dev_addr(addr_ff),
      .rsp_empty, .rsp_pop, .rsp_out_byte, .rsp_out_last
   );

   `LPC_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty, "result dropped")
   `LPC_ASSERT_IMPL(a_full_has_head, clock, reset, req_full, head_valid, "full queue without head")
   `LPC_ASSERT_NEXT(a_pop_fills, clock, reset, head_pop, !rsp_empty, "popped byte not shown")
endmodule
